[hw/rtl/klc_pkg.sv]
// Shared types, codes and reset values for the keypad lock controller.
`timescale 1ns / 1ps

package klc_pkg;

  localparam int PIN_DIGITS = 6;

  localparam int CODE_W  = 24;
  localparam int LIMIT_W = 8;
  localparam int TIME_W  = 32;
  localparam int LEN_W   = 4;
  localparam int KEY_W   = 8;
  localparam int CNT_W   = 8;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;

  localparam logic [CNT_W-1:0] FAIL_MAX = '1;

  localparam logic [KEY_W-1:0] KEY_A = 8'h41;
  localparam logic [KEY_W-1:0] KEY_B = 8'h42;
  localparam logic [KEY_W-1:0] KEY_C = 8'h43;
  localparam logic [KEY_W-1:0] KEY_D = 8'h44;

  localparam logic [LIMIT_W-1:0] FAIL_LIMIT_RST  = 8'd3;
  localparam logic [LIMIT_W-1:0] BRUTE_LIMIT_RST = 8'd5;
  localparam logic [TIME_W-1:0]  LOCKOUT_RST     = 32'd30000;
  localparam logic [TIME_W-1:0]  SESSION_RST     = 32'd30000;
  localparam logic [TIME_W-1:0]  EXTEND_RST      = 32'd60000;

  typedef enum logic [1:0] {
    OP_CONFIRM = 2'd0,
    OP_KEY     = 2'd1,
    OP_TICK    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    LVL_NONE  = 2'd0,
    LVL_USER  = 2'd1,
    LVL_ADMIN = 2'd2
  } level_e;

  typedef enum logic [3:0] {
    EV_NONE    = 4'd0,
    EV_UNLOCK  = 4'd1,
    EV_ADMIN   = 4'd2,
    EV_ERROR   = 4'd3,
    EV_BRUTE   = 4'd4,
    EV_LOCKED  = 4'd5,
    EV_TIMEOUT = 4'd6,
    EV_ENROL   = 4'd7,
    EV_WIPE    = 4'd8,
    EV_EXIT    = 4'd9,
    EV_PWDCHG  = 4'd10,
    EV_ABORT   = 4'd11
  } event_e;

  typedef enum logic [2:0] {
    REG_USER_CODE   = 3'd0,
    REG_ADMIN_CODE  = 3'd1,
    REG_FAIL_LIMIT  = 3'd2,
    REG_BRUTE_LIMIT = 3'd3,
    REG_LOCKOUT     = 3'd4,
    REG_SESSION     = 3'd5,
    REG_EXTEND      = 3'd6,
    REG_UNUSED      = 3'd7
  } reg_e;

  typedef struct packed {
    logic [CODE_W-1:0]  user_code;
    logic [CODE_W-1:0]  admin_code;
    logic [LIMIT_W-1:0] fail_limit;
    logic [LIMIT_W-1:0] brute_limit;
    logic [TIME_W-1:0]  lockout_ms;
    logic [TIME_W-1:0]  admin_session_ms;
    logic [TIME_W-1:0]  admin_extend_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [CODE_W-1:0] entry_digits;
    logic [LEN_W-1:0]  entry_length;
    logic [KEY_W-1:0]  key_code;
    logic [TIME_W-1:0] now_ms;
    logic              relay_expired;
  } item_t;

  typedef struct packed {
    level_e            level;
    logic              relay_active;
    logic              relay_pin;
    logic [CNT_W-1:0]  fail_count;
    logic              locked;
    logic [TIME_W-1:0] lock_deadline;
    logic [TIME_W-1:0] admin_deadline;
    logic              pwd_change;
    logic              enroll;
    logic              alarm;
    logic              alarm_sent;
  } state_t;

  typedef struct packed {
    level_e access_level;
    logic   relay_released;
    logic   relay_hold_start;
    event_e event_code;
    logic   alarm_active;
    logic   first_alarm;
    logic   keypad_locked;
    logic   enrol_request;
    logic   pwd_change_active;
  } result_t;

  localparam state_t STATE_RST = '{
    level:          LVL_NONE,
    relay_active:   1'b0,
    relay_pin:      1'b1,
    fail_count:     '0,
    locked:         1'b0,
    lock_deadline:  '0,
    admin_deadline: '0,
    pwd_change:     1'b0,
    enroll:         1'b0,
    alarm:          1'b0,
    alarm_sent:     1'b0
  };

endpackage

[hw/rtl/klc_step.sv]
// Next-state and result logic for one keypad lock word.
`timescale 1ns / 1ps

module klc_step import klc_pkg::*; #(
  parameter int PinDigits = PIN_DIGITS
) (
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  localparam int CmpBits = (PinDigits * 4 < CODE_W) ? PinDigits * 4 : CODE_W;
  localparam logic [CODE_W-1:0] DigitMask =
      (CmpBits >= CODE_W) ? {CODE_W{1'b1}} : CODE_W'((1 << CmpBits) - 1);
  localparam logic [LEN_W-1:0] PinLen = LEN_W'(PinDigits);

  logic              len_ok;
  logic              user_hit;
  logic              admin_hit;
  logic [CNT_W-1:0]  fail_inc;
  logic [TIME_W-1:0] duration;
  logic [TIME_W-1:0] deadline;
  logic              lock_held;
  state_t            nxt;
  event_e            ev;
  logic              hold;
  logic              first;

  assign len_ok    = (item_i.entry_length == PinLen);
  assign user_hit  = ((item_i.entry_digits ^ cfg_i.user_code) & DigitMask) == '0;
  assign admin_hit = ((item_i.entry_digits ^ cfg_i.admin_code) & DigitMask) == '0;
  assign fail_inc  = (state_i.fail_count == FAIL_MAX) ? FAIL_MAX
                                                      : state_i.fail_count + 1'b1;
  assign lock_held = state_i.locked && (item_i.now_ms < state_i.lock_deadline);

  // one shared adder for every deadline
  always_comb begin
    if (op_e'(item_i.op) == OP_CONFIRM) begin
      duration = admin_hit ? cfg_i.admin_session_ms : cfg_i.lockout_ms;
    end else begin
      duration = cfg_i.admin_extend_ms;
    end
  end

  assign deadline = item_i.now_ms + duration;

  always_comb begin
    nxt   = state_i;
    ev    = EV_NONE;
    hold  = 1'b0;
    first = 1'b0;
    case (op_e'(item_i.op))
      OP_CONFIRM: begin
        if (len_ok) begin
          if (user_hit || admin_hit) begin
            nxt.level          = user_hit ? LVL_USER : LVL_ADMIN;
            nxt.relay_active   = 1'b1;
            nxt.relay_pin      = 1'b0;
            nxt.fail_count     = '0;
            nxt.locked         = 1'b0;
            nxt.admin_deadline = user_hit ? '0 : deadline;
            nxt.alarm          = 1'b0;
            hold               = 1'b1;
            ev                 = user_hit ? EV_UNLOCK : EV_ADMIN;
          end else begin
            nxt.fail_count = fail_inc;
            if (fail_inc >= cfg_i.brute_limit) begin
              nxt.alarm = 1'b1;
              if (!state_i.alarm_sent) begin
                nxt.alarm_sent = 1'b1;
                first          = 1'b1;
              end
              ev = EV_BRUTE;
            end else if (fail_inc >= cfg_i.fail_limit) begin
              nxt.locked        = 1'b1;
              nxt.lock_deadline = deadline;
              ev                = EV_LOCKED;
            end else begin
              ev = EV_ERROR;
            end
          end
        end
      end
      OP_KEY: begin
        if (state_i.level == LVL_ADMIN) begin
          case (item_i.key_code)
            KEY_A: begin
              nxt.enroll         = 1'b1;
              nxt.admin_deadline = deadline;
              ev                 = EV_ENROL;
            end
            KEY_B: ev = EV_WIPE;
            KEY_C: begin
              nxt.level          = LVL_NONE;
              nxt.admin_deadline = '0;
              nxt.enroll         = 1'b0;
              nxt.pwd_change     = 1'b0;
              ev                 = EV_EXIT;
            end
            KEY_D: begin
              nxt.pwd_change     = 1'b1;
              nxt.admin_deadline = deadline;
              ev                 = EV_PWDCHG;
            end
            default: ev = EV_NONE;
          endcase
        end
      end
      OP_TICK: begin
        if (lock_held) begin
          nxt.relay_pin = 1'b1;
        end else begin
          if (state_i.locked) begin
            nxt.locked     = 1'b0;
            nxt.fail_count = '0;
          end
          if (state_i.level == LVL_ADMIN && state_i.admin_deadline != '0 &&
              !state_i.enroll && item_i.now_ms >= state_i.admin_deadline) begin
            nxt.admin_deadline = '0;
            nxt.level          = LVL_NONE;
            nxt.pwd_change     = 1'b0;
            ev                 = state_i.pwd_change ? EV_ABORT : EV_TIMEOUT;
          end
          if (item_i.relay_expired) begin
            nxt.relay_pin = 1'b1;
            if (state_i.relay_active) begin
              nxt.relay_active = 1'b0;
              if (nxt.level != LVL_NONE) begin
                nxt.level          = LVL_NONE;
                nxt.admin_deadline = '0;
                nxt.pwd_change     = 1'b0;
              end
            end
          end
        end
      end
      OP_CLEAR: begin
        nxt.alarm      = 1'b0;
        nxt.alarm_sent = 1'b0;
        nxt.fail_count = '0;
      end
      default: nxt = state_i;
    endcase
  end

  assign state_o = nxt;

  assign result_o = '{
    access_level:      nxt.level,
    relay_released:    nxt.relay_pin,
    relay_hold_start:  hold,
    event_code:        ev,
    alarm_active:      nxt.alarm,
    first_alarm:       first,
    keypad_locked:     nxt.locked,
    enrol_request:     nxt.enroll,
    pwd_change_active: nxt.pwd_change
  };

endmodule

[hw/rtl/keypad_lock_controller.sv]
// Top level of the keypad lock controller: register port, word pipeline, state.
//
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_stall_o   op_i .. relay_expired_i
// result    out        out_valid_o / out_stall_i access_level_o .. pwd_change_active_o
// config    in         APB psel/penable/pwrite   paddr, pwdata, prdata
//
// One word per cycle while the result is not stalled; an accepted word passes through the input register,
// then the result register, where the controller state updates.
// Reset clears the state and loads the register defaults; no warm-up pass.
// A stalled result holds; the input register still takes one more word,
// and in_stall_o rises only when both registers are full and out_stall_i is high.
`timescale 1ns / 1ps

module keypad_lock_controller import klc_pkg::*; #(
  parameter int PinDigits = PIN_DIGITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          op_i,
  input  logic [CODE_W-1:0]   entry_digits_i,
  input  logic [LEN_W-1:0]    entry_length_i,
  input  logic [KEY_W-1:0]    key_code_i,
  input  logic [TIME_W-1:0]   now_ms_i,
  input  logic                relay_expired_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          access_level_o,
  output logic                relay_released_o,
  output logic                relay_hold_start_o,
  output logic [3:0]          event_code_o,
  output logic                alarm_active_o,
  output logic                first_alarm_o,
  output logic                keypad_locked_o,
  output logic                enrol_request_o,
  output logic                pwd_change_active_o
);

  cfg_t    cfg_q;
  reg_e    reg_sel;
  logic    cfg_wr;

  logic    in_vld_q;
  item_t   in_q;
  logic    out_vld_q;
  result_t res_q;
  state_t  st_q;
  state_t  st_d;
  result_t res_d;
  logic    adv;
  logic    in_acc;

  // register port
  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.user_code        <= '0;
      cfg_q.admin_code       <= '0;
      cfg_q.fail_limit       <= FAIL_LIMIT_RST;
      cfg_q.brute_limit      <= BRUTE_LIMIT_RST;
      cfg_q.lockout_ms       <= LOCKOUT_RST;
      cfg_q.admin_session_ms <= SESSION_RST;
      cfg_q.admin_extend_ms  <= EXTEND_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_USER_CODE:   cfg_q.user_code        <= pwdata[CODE_W-1:0];
        REG_ADMIN_CODE:  cfg_q.admin_code       <= pwdata[CODE_W-1:0];
        REG_FAIL_LIMIT:  cfg_q.fail_limit       <= pwdata[LIMIT_W-1:0];
        REG_BRUTE_LIMIT: cfg_q.brute_limit      <= pwdata[LIMIT_W-1:0];
        REG_LOCKOUT:     cfg_q.lockout_ms       <= pwdata[TIME_W-1:0];
        REG_SESSION:     cfg_q.admin_session_ms <= pwdata[TIME_W-1:0];
        REG_EXTEND:      cfg_q.admin_extend_ms  <= pwdata[TIME_W-1:0];
        default:         cfg_q                  <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_USER_CODE:   prdata = DATA_W'(cfg_q.user_code);
      REG_ADMIN_CODE:  prdata = DATA_W'(cfg_q.admin_code);
      REG_FAIL_LIMIT:  prdata = DATA_W'(cfg_q.fail_limit);
      REG_BRUTE_LIMIT: prdata = DATA_W'(cfg_q.brute_limit);
      REG_LOCKOUT:     prdata = cfg_q.lockout_ms;
      REG_SESSION:     prdata = cfg_q.admin_session_ms;
      REG_EXTEND:      prdata = cfg_q.admin_extend_ms;
      default:         prdata = '0;
    endcase
  end

  // word pipeline
  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && out_vld_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= STATE_RST;
    end else begin
      in_vld_q  <= in_acc || (in_vld_q && !adv);
      out_vld_q <= adv || (out_vld_q && out_stall_i);
      if (adv) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= '{
        op:            op_i,
        entry_digits:  entry_digits_i,
        entry_length:  entry_length_i,
        key_code:      key_code_i,
        now_ms:        now_ms_i,
        relay_expired: relay_expired_i
      };
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  klc_step #(
    .PinDigits(PinDigits)
  ) u_step (
    .cfg_i   (cfg_q),
    .state_i (st_q),
    .item_i  (in_q),
    .state_o (st_d),
    .result_o(res_d)
  );

  assign out_valid_o         = out_vld_q;
  assign access_level_o      = res_q.access_level;
  assign relay_released_o    = res_q.relay_released;
  assign relay_hold_start_o  = res_q.relay_hold_start;
  assign event_code_o        = res_q.event_code;
  assign alarm_active_o      = res_q.alarm_active;
  assign first_alarm_o       = res_q.first_alarm;
  assign keypad_locked_o     = res_q.keypad_locked;
  assign enrol_request_o     = res_q.enrol_request;
  assign pwd_change_active_o = res_q.pwd_change_active;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_vld_q && in_vld_q)
    else $error("input stalled while a register is free");

  a_adv_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("advanced word did not reach the result register");

  a_first_brute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.first_alarm |-> res_q.alarm_active && res_q.event_code == EV_BRUTE)
    else $error("first alarm without brute alarm");

  a_hold_unlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.relay_hold_start |->
      !res_q.relay_released && res_q.access_level != LVL_NONE)
    else $error("relay hold start without unlock");

endmodule

[test/klc_checker.sv]
// Checker for the keypad lock controller: follows register writes, predicts and compares words.
`timescale 1ns / 1ps

module klc_checker import klc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [DATA_W-1:0] pwdata_i,

  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  item_t             in_word_i,

  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [1:0]        access_level_i,
  input  logic              relay_released_i,
  input  logic              relay_hold_start_i,
  input  logic [3:0]        event_code_i,
  input  logic              alarm_active_i,
  input  logic              first_alarm_i,
  input  logic              keypad_locked_i,
  input  logic              enrol_request_i,
  input  logic              pwd_change_active_i,

  output int                mismatches_o,
  output int                outstanding_o
);

  localparam int DIGIT_BITS = PIN_DIGITS * 4;

  cfg_t    lock_cfg;
  state_t  lock_st;
  result_t due_results[$];
  int      mismatch_total = 0;

  assign mismatches_o  = mismatch_total;
  assign outstanding_o = due_results.size();

  function automatic void grant_access(level_e lvl, logic [TIME_W-1:0] deadline);
    lock_st.level          = lvl;
    lock_st.relay_active   = 1'b1;
    lock_st.relay_pin      = 1'b0;
    lock_st.fail_count     = '0;
    lock_st.locked         = 1'b0;
    lock_st.admin_deadline = deadline;
    lock_st.alarm          = 1'b0;
  endfunction

  function automatic result_t advance_lock(item_t w);
    result_t r;
    event_e  ev;
    logic    hold_start;
    logic    first;
    logic    held;
    ev         = EV_NONE;
    hold_start = 1'b0;
    first      = 1'b0;
    held       = 1'b0;
    case (op_e'(w.op))
      OP_CONFIRM: begin
        if (w.entry_length == LEN_W'(PIN_DIGITS)) begin
          if (w.entry_digits[DIGIT_BITS-1:0] == lock_cfg.user_code[DIGIT_BITS-1:0]) begin
            grant_access(LVL_USER, '0);
            hold_start = 1'b1;
            ev = EV_UNLOCK;
          end else if (w.entry_digits[DIGIT_BITS-1:0] ==
                       lock_cfg.admin_code[DIGIT_BITS-1:0]) begin
            grant_access(LVL_ADMIN, w.now_ms + lock_cfg.admin_session_ms);
            hold_start = 1'b1;
            ev = EV_ADMIN;
          end else begin
            if (lock_st.fail_count != FAIL_MAX) lock_st.fail_count = lock_st.fail_count + 1'b1;
            if (lock_st.fail_count >= lock_cfg.brute_limit) begin
              lock_st.alarm = 1'b1;
              if (!lock_st.alarm_sent) begin
                lock_st.alarm_sent = 1'b1;
                first = 1'b1;
              end
              ev = EV_BRUTE;
            end else if (lock_st.fail_count >= lock_cfg.fail_limit) begin
              lock_st.locked = 1'b1;
              lock_st.lock_deadline = w.now_ms + lock_cfg.lockout_ms;
              ev = EV_LOCKED;
            end else begin
              ev = EV_ERROR;
            end
          end
        end
      end
      OP_KEY: begin
        if (lock_st.level == LVL_ADMIN) begin
          case (w.key_code)
            KEY_A: begin
              lock_st.enroll = 1'b1;
              lock_st.admin_deadline = w.now_ms + lock_cfg.admin_extend_ms;
              ev = EV_ENROL;
            end
            KEY_B: ev = EV_WIPE;
            KEY_C: begin
              lock_st.level = LVL_NONE;
              lock_st.admin_deadline = '0;
              lock_st.enroll = 1'b0;
              lock_st.pwd_change = 1'b0;
              ev = EV_EXIT;
            end
            KEY_D: begin
              lock_st.pwd_change = 1'b1;
              lock_st.admin_deadline = w.now_ms + lock_cfg.admin_extend_ms;
              ev = EV_PWDCHG;
            end
            default: ;
          endcase
        end
      end
      OP_TICK: begin
        if (lock_st.locked) begin
          if (w.now_ms < lock_st.lock_deadline) begin
            lock_st.relay_pin = 1'b1;
            held = 1'b1;
          end else begin
            lock_st.locked = 1'b0;
            lock_st.fail_count = '0;
          end
        end
        if (!held) begin
          if (lock_st.level == LVL_ADMIN && lock_st.admin_deadline != '0 && !lock_st.enroll &&
              w.now_ms >= lock_st.admin_deadline) begin
            lock_st.admin_deadline = '0;
            lock_st.level = LVL_NONE;
            if (lock_st.pwd_change) begin
              lock_st.pwd_change = 1'b0;
              ev = EV_ABORT;
            end else begin
              ev = EV_TIMEOUT;
            end
          end
          if (w.relay_expired) begin
            lock_st.relay_pin = 1'b1;
            if (lock_st.relay_active) begin
              lock_st.relay_active = 1'b0;
              if (lock_st.level != LVL_NONE) begin
                lock_st.level = LVL_NONE;
                lock_st.admin_deadline = '0;
                lock_st.pwd_change = 1'b0;
              end
            end
          end
        end
      end
      default: begin
        lock_st.alarm = 1'b0;
        lock_st.alarm_sent = 1'b0;
        lock_st.fail_count = '0;
      end
    endcase
    r.access_level      = lock_st.level;
    r.relay_released    = lock_st.relay_pin;
    r.relay_hold_start  = hold_start;
    r.event_code        = ev;
    r.alarm_active      = lock_st.alarm;
    r.first_alarm       = first;
    r.keypad_locked     = lock_st.locked;
    r.enrol_request     = lock_st.enroll;
    r.pwd_change_active = lock_st.pwd_change;
    return r;
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned seen);
    if (want != seen) begin
      $display("%0t: %s differs, expected %0d, actual %0d", $time, field, want, seen);
      mismatch_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t want;
    if (!rst_ni) begin
      lock_cfg.user_code        = '0;
      lock_cfg.admin_code       = '0;
      lock_cfg.fail_limit       = FAIL_LIMIT_RST;
      lock_cfg.brute_limit      = BRUTE_LIMIT_RST;
      lock_cfg.lockout_ms       = LOCKOUT_RST;
      lock_cfg.admin_session_ms = SESSION_RST;
      lock_cfg.admin_extend_ms  = EXTEND_RST;
      lock_st = STATE_RST;
      due_results.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_e'(paddr_i[ADDR_W-1:2]))
          REG_USER_CODE:   lock_cfg.user_code        = pwdata_i[CODE_W-1:0];
          REG_ADMIN_CODE:  lock_cfg.admin_code       = pwdata_i[CODE_W-1:0];
          REG_FAIL_LIMIT:  lock_cfg.fail_limit       = pwdata_i[LIMIT_W-1:0];
          REG_BRUTE_LIMIT: lock_cfg.brute_limit      = pwdata_i[LIMIT_W-1:0];
          REG_LOCKOUT:     lock_cfg.lockout_ms       = pwdata_i[TIME_W-1:0];
          REG_SESSION:     lock_cfg.admin_session_ms = pwdata_i[TIME_W-1:0];
          REG_EXTEND:      lock_cfg.admin_extend_ms  = pwdata_i[TIME_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $display("%0t: result word with nothing predicted, event %0d", $time, event_code_i);
          mismatch_total++;
        end else begin
          want = due_results.pop_front();
          check_field("access_level", want.access_level, access_level_i);
          check_field("relay_released", want.relay_released, relay_released_i);
          check_field("relay_hold_start", want.relay_hold_start, relay_hold_start_i);
          check_field("event_code", want.event_code, event_code_i);
          check_field("alarm_active", want.alarm_active, alarm_active_i);
          check_field("first_alarm", want.first_alarm, first_alarm_i);
          check_field("keypad_locked", want.keypad_locked, keypad_locked_i);
          check_field("enrol_request", want.enrol_request, enrol_request_i);
          check_field("pwd_change_active", want.pwd_change_active, pwd_change_active_i);
        end
      end
      if (in_valid_i && !in_stall_i) due_results.push_back(advance_lock(in_word_i));
    end
  end

endmodule

[test/tb_keypad_lock_controller.sv]
// Testbench top for the keypad lock controller: clock, reset, register writes and keypad words.
`timescale 1ns / 1ps

module tb_keypad_lock_controller import klc_pkg::*;;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_stall;
  item_t             word;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        access_level;
  logic              relay_released;
  logic              relay_hold_start;
  logic [3:0]        event_code;
  logic              alarm_active;
  logic              first_alarm;
  logic              keypad_locked;
  logic              enrol_request;
  logic              pwd_change_active;
  int                mismatches;
  int                outstanding;

  int                hold_req = 0;
  int                burst_left = 0;
  int                step_max = 300;
  bit                gaps_on = 1'b1;
  logic [TIME_W-1:0] now_base = '0;
  logic [CODE_W-1:0] cur_user = '0;
  logic [CODE_W-1:0] cur_admin = '0;

  keypad_lock_controller uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .op_i                (word.op),
    .entry_digits_i      (word.entry_digits),
    .entry_length_i      (word.entry_length),
    .key_code_i          (word.key_code),
    .now_ms_i            (word.now_ms),
    .relay_expired_i     (word.relay_expired),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .access_level_o      (access_level),
    .relay_released_o    (relay_released),
    .relay_hold_start_o  (relay_hold_start),
    .event_code_o        (event_code),
    .alarm_active_o      (alarm_active),
    .first_alarm_o       (first_alarm),
    .keypad_locked_o     (keypad_locked),
    .enrol_request_o     (enrol_request),
    .pwd_change_active_o (pwd_change_active)
  );

  klc_checker u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel_i              (psel),
    .penable_i           (penable),
    .pwrite_i            (pwrite),
    .pready_i            (pready),
    .paddr_i             (paddr),
    .pwdata_i            (pwdata),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .in_word_i           (word),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .access_level_i      (access_level),
    .relay_released_i    (relay_released),
    .relay_hold_start_i  (relay_hold_start),
    .event_code_i        (event_code),
    .alarm_active_i      (alarm_active),
    .first_alarm_i       (first_alarm),
    .keypad_locked_i     (keypad_locked),
    .enrol_request_i     (enrol_request),
    .pwd_change_active_i (pwd_change_active),
    .mismatches_o        (mismatches),
    .outstanding_o       (outstanding)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // receiver: rotating stall pattern, plus a long hold-off on request
  initial begin : receiver
    int held_reqs;
    int cyc;
    held_reqs = 0;
    cyc = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != held_reqs) begin
        held_reqs = hold_req;
        out_stall = 1'b1;
        repeat (60) @(negedge clk_i);
      end
      cyc++;
      case ((cyc / 48) % 4)
        0:       out_stall = 1'b0;
        1:       out_stall = ($urandom_range(0, 3) == 0);
        2:       out_stall = ($urandom_range(0, 9) < 6);
        default: out_stall = (cyc % 3 == 0);
      endcase
    end
  end

  function automatic item_t lock_word(op_e op, logic [CODE_W-1:0] digits,
                                      logic [LEN_W-1:0] len, logic [KEY_W-1:0] key,
                                      logic [TIME_W-1:0] now, logic expired);
    item_t w;
    w.op            = op;
    w.entry_digits  = digits;
    w.entry_length  = len;
    w.key_code      = key;
    w.now_ms        = now;
    w.relay_expired = expired;
    return w;
  endfunction

  function automatic item_t random_word(bit failing);
    item_t w;
    int    pick;
    w.op            = op_e'($urandom_range(0, 3));
    w.entry_digits  = CODE_W'($urandom);
    w.entry_length  = LEN_W'($urandom);
    w.key_code      = KEY_W'($urandom);
    w.relay_expired = 1'($urandom);
    now_base = now_base + TIME_W'($urandom_range(0, step_max));
    w.now_ms = ($urandom_range(0, 19) == 0) ? TIME_W'($urandom) : now_base;
    pick = $urandom_range(0, 99);
    if (failing) begin
      if (pick < 95) begin
        w.op = OP_CONFIRM;
        w.entry_length = LEN_W'(PIN_DIGITS);
        while (w.entry_digits == cur_user || w.entry_digits == cur_admin)
          w.entry_digits = CODE_W'($urandom);
      end else begin
        w.op = OP_KEY;
      end
    end else if (pick < 40) begin
      w.op = OP_CONFIRM;
      if ($urandom_range(0, 9) != 0) w.entry_length = LEN_W'(PIN_DIGITS);
      pick = $urandom_range(0, 99);
      if (pick < 35) w.entry_digits = cur_user;
      else if (pick < 65) w.entry_digits = cur_admin;
    end else if (pick < 65) begin
      w.op = OP_KEY;
      if ($urandom_range(0, 6) != 0) w.key_code = KEY_A + KEY_W'($urandom_range(0, 3));
    end else if (pick < 93) begin
      w.op = OP_TICK;
      w.relay_expired = ($urandom_range(0, 3) == 0);
    end else begin
      w.op = OP_CLEAR;
    end
    return w;
  endfunction

  // drive one word at the falling edge and hold it until taken
  task automatic offer(item_t w);
    word = w;
    in_valid = 1'b1;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on && $urandom_range(0, 2) != 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
      end
    end
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [DATA_W-1:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic apply_settings(logic [CODE_W-1:0] user, logic [CODE_W-1:0] admin,
                                logic [LIMIT_W-1:0] fail_lim, logic [LIMIT_W-1:0] brute_lim,
                                logic [TIME_W-1:0] lockout, logic [TIME_W-1:0] session,
                                logic [TIME_W-1:0] extend);
    drain();
    repeat (3) @(negedge clk_i);
    write_reg(REG_USER_CODE, DATA_W'(user));
    write_reg(REG_ADMIN_CODE, DATA_W'(admin));
    write_reg(REG_FAIL_LIMIT, DATA_W'(fail_lim));
    write_reg(REG_BRUTE_LIMIT, DATA_W'(brute_lim));
    write_reg(REG_LOCKOUT, lockout);
    write_reg(REG_SESSION, session);
    write_reg(REG_EXTEND, extend);
    cur_user = user;
    cur_admin = admin;
  endtask

  task automatic run_random(int count, bit failing);
    repeat (count) offer(random_word(failing));
  endtask

  initial begin : stimulus
    logic [LEN_W-1:0]  six;
    logic [CODE_W-1:0] shared_code;
    six = LEN_W'(PIN_DIGITS);
    rst_ni = 1'b0;
    in_valid = 1'b0;
    word = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    apply_settings(24'h123456, 24'h654321, 8'd3, 8'd5, 32'd1000, 32'd500, 32'd2000);
    offer(lock_word(OP_CONFIRM, cur_user, six, '0, 32'd100, 1'b0));
    offer(lock_word(OP_TICK, '0, '0, '0, 32'd110, 1'b1));
    offer(lock_word(OP_CONFIRM, cur_admin, six, '0, 32'd120, 1'b0));
    offer(lock_word(OP_KEY, '0, '0, KEY_A, 32'd130, 1'b0));
    offer(lock_word(OP_KEY, '0, '0, KEY_B, 32'd131, 1'b0));
    offer(lock_word(OP_KEY, '0, '0, KEY_D + 8'd1, 32'd132, 1'b0));
    offer(lock_word(OP_KEY, '0, '0, '1, 32'd133, 1'b0));
    offer(lock_word(OP_KEY, '0, '0, KEY_D, 32'd134, 1'b0));
    offer(lock_word(OP_KEY, '0, '0, KEY_C, 32'd135, 1'b0));
    offer(lock_word(OP_KEY, '0, '0, KEY_A, 32'd136, 1'b0));
    // wrong entry length is ignored even with a valid code
    offer(lock_word(OP_CONFIRM, cur_user, six - 4'd1, '0, 32'd140, 1'b0));
    offer(lock_word(OP_CONFIRM, '1, '1, '0, 32'd141, 1'b0));
    offer(lock_word(OP_CONFIRM, '1, six, '0, 32'd150, 1'b0));
    offer(lock_word(OP_CONFIRM, '0, six, '0, 32'd160, 1'b0));
    offer(lock_word(OP_CONFIRM, 24'hABCDEF, six, '0, 32'd200, 1'b0));
    offer(lock_word(OP_TICK, '0, '0, '0, 32'd300, 1'b1));
    // entries still checked while locked; then brute alarm, first and repeat
    offer(lock_word(OP_CONFIRM, 24'h111111, six, '0, 32'd310, 1'b0));
    offer(lock_word(OP_CONFIRM, 24'h222222, six, '0, 32'd320, 1'b0));
    offer(lock_word(OP_CONFIRM, 24'h333333, six, '0, 32'd330, 1'b0));
    offer(lock_word(OP_TICK, '0, '0, '0, 32'd5000, 1'b0));
    offer(lock_word(OP_CLEAR, '0, '0, '0, 32'd5001, 1'b0));
    offer(lock_word(OP_CONFIRM, cur_admin, six, '0, 32'd6000, 1'b0));
    offer(lock_word(OP_KEY, '0, '0, KEY_D, 32'd6010, 1'b0));
    offer(lock_word(OP_TICK, '0, '0, '0, 32'd9000, 1'b0));
    // session deadline wraps past 2^32
    offer(lock_word(OP_CONFIRM, cur_admin, six, '0, 32'hFFFF_FFF0, 1'b0));
    offer(lock_word(OP_TICK, '0, '0, '0, '1, 1'b0));

    now_base = 32'd10000;
    step_max = 300;
    run_random(60, 1'b0);
    drain();
    run_random(40, 1'b0);
    hold_req++;
    run_random(100, 1'b0);

    apply_settings('1, '0, 8'd1, 8'd1, '0, '0, '0);
    gaps_on = 1'b0;
    step_max = 50;
    run_random(120, 1'b0);

    // long run of misses drives the failure count into saturation
    apply_settings(CODE_W'($urandom), CODE_W'($urandom), '1, '1, '1, '1, '1);
    gaps_on = 1'b1;
    step_max = 1000;
    run_random(270, 1'b1);

    // same code for user and admin: user match wins
    shared_code = CODE_W'($urandom);
    apply_settings(shared_code, shared_code, 8'd2, 8'd4, TIME_W'($urandom_range(1, 5000)),
                   TIME_W'($urandom_range(1, 5000)), TIME_W'($urandom_range(1, 5000)));
    hold_req++;
    run_random(75, 1'b0);
    apply_settings(CODE_W'($urandom), CODE_W'($urandom), 8'd2, 8'd4,
                   TIME_W'($urandom_range(1, 5000)), TIME_W'($urandom_range(1, 5000)),
                   TIME_W'($urandom_range(1, 5000)));
    run_random(75, 1'b0);

    drain();
    repeat (5) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
